>>> src/fifo_job_scheduler_assert.svh
// Assertion macros shared by the job scheduler modules.
`ifndef FIFO_JOB_SCHEDULER_ASSERT_SVH
`define FIFO_JOB_SCHEDULER_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define FJS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fifo_job_scheduler assertion failed");

// Same-cycle implication.
`define FJS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fifo_job_scheduler assertion failed");

// Next-cycle implication.
`define FJS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fifo_job_scheduler assertion failed");

`endif

>>> src/fjs_pkg.sv
// Types and constants for the FIFO job scheduler.
package fjs_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int PAGE_BITS       = 10;
  localparam int SPP_BITS        = 8;
  localparam int STAMP_BITS      = 32;
  localparam int BUSY_BITS       = 18;
  localparam int SUM_BITS        = 48;
  localparam int QUEUED_BITS     = 5;

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [PAGE_BITS-1:0] pages;
  } item_t;

  typedef struct packed {
    logic                   accepted;
    logic                   started;
    logic [PAGE_BITS-1:0]   served_pages;
    logic [STAMP_BITS-1:0]  served_wait;
    logic [STAMP_BITS-1:0]  jobs_seen;
    logic [SUM_BITS-1:0]    latency_total;
    logic [BUSY_BITS-1:0]   busy_left;
    logic [QUEUED_BITS-1:0] queued;
    logic [STAMP_BITS-1:0]  now;
  } result_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0]  pages;
    logic [STAMP_BITS-1:0] stamp;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

endpackage

>>> src/fifo_job_scheduler.sv
// Top level of the FIFO job scheduler.
// Takes one item (arrival or tick) per cycle: an item accepted on start & !busy
// gives its result beat on done after passing the input register and the result
// register, and items may follow back to back with no gaps. Between the two
// registers lies the single execute step (queue update,
// 10x8 service-time multiply, 48-bit saturating latency add). busy is high
// only during and just after reset. done/result cannot be stalled, so the
// receiver must take every beat in the cycle it appears. The per-page service
// rate may be written through cfg_we/cfg_wdata only while no item is in flight.
`include "fifo_job_scheduler_assert.svh"

module fifo_job_scheduler #(
  parameter int QUEUE_DEPTH = fjs_pkg::DEF_QUEUE_DEPTH,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  fjs_pkg::item_t               item,
  input  logic                         cfg_we,
  input  logic [fjs_pkg::SPP_BITS-1:0] cfg_wdata,
  output logic                         done,
  output fjs_pkg::result_t             result
);
  import fjs_pkg::*;

  logic                  held;
  item_t                 held_item;
  logic [SPP_BITS-1:0]   spp;
  logic [STAMP_BITS-1:0] clock_now;
  logic [STAMP_BITS-1:0] clock_now_next;
  logic [BUSY_BITS-1:0]  busy_cnt;
  logic [BUSY_BITS-1:0]  busy_cnt_next;
  logic [STAMP_BITS-1:0] job_total;
  logic [STAMP_BITS-1:0] job_total_next;
  logic [SUM_BITS-1:0]   wait_sum;
  logic [SUM_BITS-1:0]   wait_sum_next;
  result_t               result_next;

  qctl_t                 qctl;
  job_t                  wr_job;
  job_t                  head_job;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;

  logic                  arrival;
  logic                  tick;
  logic [BUSY_BITS-1:0]  load;
  logic [BUSY_BITS-1:0]  busy_mid;
  logic [STAMP_BITS-1:0] wait_ticks;
  logic [SUM_BITS:0]     sum_wide;

  fjs_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .ctl        (qctl),
    .wr_job     (wr_job),
    .head_job   (head_job),
    .count      (count),
    .count_next (count_next)
  );

  always_comb begin
    arrival   = held && (held_item.op == OP_ARRIVAL);
    tick      = held && (held_item.op == OP_TICK);
    qctl.push = arrival && (count != CW'(QUEUE_DEPTH));
    qctl.pop  = tick && (busy_cnt == '0) && (count != '0);

    wr_job.pages = held_item.pages;
    wr_job.stamp = clock_now;

    // 1023 * 255 fits in 18 bits, so the product never saturates
    load       = BUSY_BITS'(head_job.pages) * BUSY_BITS'(spp);
    busy_mid   = qctl.pop ? load : busy_cnt;
    wait_ticks = clock_now - head_job.stamp;
    sum_wide   = {1'b0, wait_sum} + (SUM_BITS + 1)'(wait_ticks);

    busy_cnt_next  = busy_cnt;
    clock_now_next = clock_now;
    if (tick) begin
      busy_cnt_next  = (busy_mid != '0) ? busy_mid - 1'b1 : busy_mid;
      clock_now_next = clock_now + 1'b1;
    end

    wait_sum_next = wait_sum;
    if (qctl.pop) begin
      wait_sum_next = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
    end

    job_total_next = qctl.push ? job_total + 1'b1 : job_total;

    result_next.accepted      = qctl.push;
    result_next.started       = qctl.pop;
    result_next.served_pages  = qctl.pop ? head_job.pages : '0;
    result_next.served_wait   = qctl.pop ? wait_ticks : '0;
    result_next.jobs_seen     = job_total_next;
    result_next.latency_total = wait_sum_next;
    result_next.busy_left     = busy_cnt_next;
    result_next.queued        = QUEUED_BITS'(count_next);
    result_next.now           = clock_now_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      done      <= 1'b0;
      busy      <= 1'b1;
      spp       <= SPP_BITS'(1);
      clock_now <= '0;
      busy_cnt  <= '0;
      job_total <= '0;
      wait_sum  <= '0;
    end else begin
      held      <= start && !busy;
      done      <= held;
      busy      <= 1'b0;
      clock_now <= clock_now_next;
      busy_cnt  <= busy_cnt_next;
      job_total <= job_total_next;
      wait_sum  <= wait_sum_next;
      if (cfg_we) begin
        spp <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_item <= item;
    result    <= result_next;
  end

  `FJS_ASSERT_NEXT(a_beat_in_flight, start && !busy, held)
  `FJS_ASSERT_IMP(a_start_when_idle, done && result.started, $past(busy_cnt) == '0)
  `FJS_ASSERT_NEXT(a_sum_only_on_start, !qctl.pop, wait_sum == $past(wait_sum))

endmodule

>>> src/fjs_queue.sv
// Job queue: circular buffer in a memory with a registered head read.
`include "fifo_job_scheduler_assert.svh"

module fjs_queue #(
  parameter int QUEUE_DEPTH = fjs_pkg::DEF_QUEUE_DEPTH,
  localparam int PW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  fjs_pkg::qctl_t ctl,
  input  fjs_pkg::job_t  wr_job,
  output fjs_pkg::job_t  head_job,
  output logic [CW-1:0]  count,
  output logic [CW-1:0]  count_next
);
  import fjs_pkg::*;

  job_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] head_next;
  logic [PW-1:0] tail;
  logic [PW-1:0] tail_next;

  always_comb begin
    head_next = head;
    tail_next = tail;
    count_next = count;
    if (ctl.pop) begin
      head_next = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      count_next = count - 1'b1;
    end
    if (ctl.push) begin
      tail_next = (tail == PW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // head_job always holds the entry at head; a write into that slot is forwarded
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wr_job;
    end
    if (ctl.push && tail == head_next) begin
      head_job <= wr_job;
    end else begin
      head_job <= mem[head_next];
    end
  end

  `FJS_ASSERT_ALWAYS(a_no_push_pop, !(ctl.push && ctl.pop))
  `FJS_ASSERT_ALWAYS(a_fill_bound, count <= CW'(QUEUE_DEPTH))
  `FJS_ASSERT_IMP(a_no_overrun, ctl.push, count != CW'(QUEUE_DEPTH))
  `FJS_ASSERT_IMP(a_no_underrun, ctl.pop, count != '0)

endmodule
